@@ hw/rtl/ctps_pkg.sv @@
`default_nettype none

package ctps_pkg;

	localparam int TASK_COUNT_DEF = 64;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_PAUSE = 2'd2;

	localparam logic [8:0] INIT_SLICE = 9'd15;
	localparam logic [7:0] INIT_PRIO  = 8'd15;

	typedef struct packed {
		logic [1:0] op;
		logic       user_mode;
		logic [5:0] task_index;
		logic       task_present;
		logic       task_runnable;
		logic [7:0] task_priority;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  current_task;
		logic        switched;
		logic [8:0]  current_counter;
		logic [31:0] user_ticks;
		logic [31:0] system_ticks;
	} out_item_t;

	typedef struct packed {
		logic [7:0] prio;
		logic [8:0] cnt;
	} slice_t;

	typedef struct packed {
		logic [31:0] user;
		logic [31:0] sys;
	} ticks_t;

	typedef struct packed {
		logic load;
		logic rd_cur;
		logic rd_scan;
		logic rec;
		logic scan_clr;
		logic scan_inc;
		logic tick_wr;
		logic set_wr;
		logic pause_clr;
		logic best_clr;
		logic commit;
		logic sw_set;
		logic emit_tick;
		logic emit_rpt;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       resched;
		logic       scan_last;
		logic       need_rc;
	} sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/counter_priority_task_scheduler.sv @@
// Channel   Ports                Transaction
// ------    -------------------  ------------------------------------------
// event     start, busy, item    accepted at a clock edge with start high, busy low
// result    done, result         valid for the single cycle that done is high
//
// Accept to result: a tick without reschedule passes dispatch and tick write; set
// task or an unused op, dispatch, report read and report output. A pause or a
// rescheduling tick scans the table first; when every runnable slice is spent,
// a recharge pass follows it. Reset is asynchronous; valid bits give entry 0 its
// initial slice and priority and all tick counts zero, with no clearing pass.
// The receiver cannot stall; done is high once, in the first cycle busy is low.
`default_nettype none

module counter_priority_task_scheduler #(
	parameter int TASK_COUNT = ctps_pkg::TASK_COUNT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire ctps_pkg::in_item_t item,
	output logic                    done,
	output ctps_pkg::out_item_t     result
);

	ctps_pkg::cmd_t cmd;
	ctps_pkg::sts_t sts;

	ctps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	ctps_dp #(
		.TASK_COUNT (TASK_COUNT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result),
		.done   (done)
	);

endmodule

`default_nettype wire

@@ hw/rtl/ctps_ctrl.sv @@
`default_nettype none

module ctps_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	output ctps_pkg::cmd_t     cmd,
	input  wire ctps_pkg::sts_t sts
);

	typedef enum logic [10:0] {
		S_IDLE       = 11'b000_0000_0001,
		S_DISPATCH   = 11'b000_0000_0010,
		S_TICK_WR    = 11'b000_0000_0100,
		S_SCAN       = 11'b000_0000_1000,
		S_SCAN_DRAIN = 11'b000_0001_0000,
		S_DECIDE     = 11'b000_0010_0000,
		S_REC        = 11'b000_0100_0000,
		S_REC_DRAIN  = 11'b000_1000_0000,
		S_REC_DONE   = 11'b001_0000_0000,
		S_RPT_RD     = 11'b010_0000_0000,
		S_RPT_OUT    = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.op)
					ctps_pkg::OP_TICK: begin
						cmd.rd_cur = 1'b1;
						state_d    = S_TICK_WR;
					end
					ctps_pkg::OP_SET: begin
						cmd.set_wr = 1'b1;
						state_d    = S_RPT_RD;
					end
					ctps_pkg::OP_PAUSE: begin
						cmd.pause_clr = 1'b1;
						cmd.scan_clr  = 1'b1;
						cmd.best_clr  = 1'b1;
						cmd.sw_set    = 1'b1;
						state_d       = S_SCAN;
					end
					default: begin
						state_d = S_RPT_RD;
					end
				endcase
			end
			S_TICK_WR: begin
				cmd.tick_wr = 1'b1;
				if (sts.resched) begin
					cmd.scan_clr = 1'b1;
					cmd.best_clr = 1'b1;
					cmd.sw_set   = 1'b1;
					state_d      = S_SCAN;
				end else begin
					cmd.emit_tick = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.rd_scan  = 1'b1;
				cmd.scan_inc = 1'b1;
				if (sts.scan_last) begin
					state_d = S_SCAN_DRAIN;
				end
			end
			S_SCAN_DRAIN: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				// Every runnable slice is spent: recharge all present tasks once.
				if (sts.need_rc) begin
					cmd.scan_clr = 1'b1;
					cmd.best_clr = 1'b1;
					state_d      = S_REC;
				end else begin
					cmd.commit = 1'b1;
					state_d    = S_RPT_RD;
				end
			end
			S_REC: begin
				cmd.rd_scan  = 1'b1;
				cmd.rec      = 1'b1;
				cmd.scan_inc = 1'b1;
				if (sts.scan_last) begin
					state_d = S_REC_DRAIN;
				end
			end
			S_REC_DRAIN: begin
				state_d = S_REC_DONE;
			end
			S_REC_DONE: begin
				cmd.commit = 1'b1;
				state_d    = S_RPT_RD;
			end
			S_RPT_RD: begin
				cmd.rd_cur = 1'b1;
				state_d    = S_RPT_OUT;
			end
			S_RPT_OUT: begin
				cmd.emit_rpt = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_emit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_tick || cmd.emit_rpt) |=> (state_q == S_IDLE))
		else $error("result emitted without returning to idle");

	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_DRAIN) |-> $past(sts.scan_last))
		else $error("scan pass ended before the last entry");

	a_commit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> !cmd.commit && (state_q == S_RPT_RD))
		else $error("commit not followed by report read");

endmodule

`default_nettype wire

@@ hw/rtl/ctps_dp.sv @@
`default_nettype none

module ctps_dp #(
	parameter int TASK_COUNT = ctps_pkg::TASK_COUNT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ctps_pkg::in_item_t  item,
	input  wire ctps_pkg::cmd_t      cmd,
	output ctps_pkg::sts_t           sts,
	output ctps_pkg::out_item_t      result,
	output logic                     done
);

	localparam int IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

	ctps_pkg::in_item_t  req_q;
	ctps_pkg::out_item_t res_q;
	logic                done_q;
	logic                sw_q;

	logic [IW-1:0] running_q, scan_q, best_idx_q, a_s1;
	logic [IW-1:0] rd_addr, wr_addr, set_addr;
	logic [8:0]    best_cnt_q;
	logic          found_q;

	logic [TASK_COUNT-1:0] present_q, runnable_q, sl_ok_q, tk_ok_q;

	ctps_pkg::slice_t sl_mem_q [TASK_COUNT];
	ctps_pkg::ticks_t tk_mem_q [TASK_COUNT];

	ctps_pkg::slice_t sl_rd_s1, sl_cur, sl_wd;
	ctps_pkg::ticks_t tk_rd_s1, tk_cur, tk_wd;
	logic             sl_ok_s1, tk_ok_s1, v_s1, rc_s1;

	logic       rd_en, sl_we, set_ok, cand;
	logic [8:0] dec_cnt, rc_cnt, eff_cnt;

	assign rd_addr  = cmd.rd_scan ? scan_q : running_q;
	assign rd_en    = cmd.rd_cur | cmd.rd_scan;
	assign set_addr = IW'(req_q.task_index);
	assign set_ok   = (32'(req_q.task_index) < 32'(TASK_COUNT));

	// Entries never written read as their reset contents.
	always_comb begin
		if (sl_ok_s1) begin
			sl_cur = sl_rd_s1;
		end else if (a_s1 == '0) begin
			sl_cur = '{prio: ctps_pkg::INIT_PRIO, cnt: ctps_pkg::INIT_SLICE};
		end else begin
			sl_cur = '0;
		end
		tk_cur = tk_ok_s1 ? tk_rd_s1 : '0;
	end

	assign dec_cnt = (sl_cur.cnt > 9'd1) ? (sl_cur.cnt - 9'd1) : 9'd0;
	assign rc_cnt  = {1'b0, sl_cur.cnt[8:1]} + {1'b0, sl_cur.prio};
	assign eff_cnt = rc_s1 ? rc_cnt : sl_cur.cnt;
	assign cand    = v_s1 & present_q[a_s1] & runnable_q[a_s1];

	assign tk_wd.user = tk_cur.user + 32'(req_q.user_mode);
	assign tk_wd.sys  = tk_cur.sys + 32'(!req_q.user_mode);

	always_comb begin
		sl_we   = 1'b0;
		wr_addr = running_q;
		sl_wd   = '{prio: sl_cur.prio, cnt: dec_cnt};
		if (cmd.tick_wr) begin
			sl_we = 1'b1;
		end else if (cmd.set_wr && set_ok) begin
			sl_we   = 1'b1;
			wr_addr = set_addr;
			sl_wd   = '{prio: req_q.task_priority, cnt: {1'b0, req_q.task_priority}};
		end else if (v_s1 && rc_s1 && present_q[a_s1]) begin
			sl_we   = 1'b1;
			wr_addr = a_s1;
			sl_wd   = '{prio: sl_cur.prio, cnt: rc_cnt};
		end
	end

	always_ff @(posedge clk) begin
		if (sl_we) begin
			sl_mem_q[wr_addr] <= sl_wd;
		end
		if (cmd.tick_wr) begin
			tk_mem_q[running_q] <= tk_wd;
		end
		if (rd_en) begin
			sl_rd_s1 <= sl_mem_q[rd_addr];
			tk_rd_s1 <= tk_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= item;
		end
		if (rd_en) begin
			a_s1 <= rd_addr;
		end
		if (cmd.emit_tick) begin
			res_q <= '{current_task: 6'(running_q), switched: sw_q,
				current_counter: dec_cnt, user_ticks: tk_wd.user, system_ticks: tk_wd.sys};
		end else if (cmd.emit_rpt) begin
			res_q <= '{current_task: 6'(running_q), switched: sw_q,
				current_counter: sl_cur.cnt, user_ticks: tk_cur.user, system_ticks: tk_cur.sys};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q  <= TASK_COUNT'(1);
			runnable_q <= TASK_COUNT'(1);
			sl_ok_q    <= '0;
			tk_ok_q    <= '0;
			running_q  <= '0;
			scan_q     <= '0;
			best_idx_q <= '0;
			best_cnt_q <= '0;
			found_q    <= 1'b0;
			sl_ok_s1   <= 1'b0;
			tk_ok_s1   <= 1'b0;
			v_s1       <= 1'b0;
			rc_s1      <= 1'b0;
			sw_q       <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			v_s1   <= cmd.rd_scan;
			rc_s1  <= cmd.rec;
			done_q <= cmd.emit_tick | cmd.emit_rpt;
			if (rd_en) begin
				sl_ok_s1 <= sl_ok_q[rd_addr];
				tk_ok_s1 <= tk_ok_q[rd_addr];
			end
			if (sl_we) begin
				sl_ok_q[wr_addr] <= 1'b1;
			end
			if (cmd.tick_wr) begin
				tk_ok_q[running_q] <= 1'b1;
			end
			if (cmd.set_wr && set_ok) begin
				present_q[set_addr]  <= req_q.task_present;
				runnable_q[set_addr] <= req_q.task_runnable;
			end
			if (cmd.pause_clr) begin
				runnable_q[running_q] <= 1'b0;
			end
			if (cmd.load) begin
				sw_q <= 1'b0;
			end else if (cmd.sw_set) begin
				sw_q <= 1'b1;
			end
			if (cmd.scan_clr) begin
				scan_q <= '0;
			end else if (cmd.scan_inc) begin
				scan_q <= scan_q + IW'(1);
			end
			// Ascending scan with >= lets the highest index win a tie.
			if (cmd.best_clr) begin
				found_q <= 1'b0;
			end else if (cand && (!found_q || eff_cnt >= best_cnt_q)) begin
				found_q    <= 1'b1;
				best_idx_q <= a_s1;
				best_cnt_q <= eff_cnt;
			end
			if (cmd.commit) begin
				running_q <= found_q ? best_idx_q : '0;
			end
		end
	end

	assign sts.op        = req_q.op;
	assign sts.resched   = (sl_cur.cnt <= 9'd1) & req_q.user_mode;
	assign sts.scan_last = (scan_q == IW'(TASK_COUNT - 1));
	assign sts.need_rc   = found_q & (best_cnt_q == 9'd0);

	assign result = res_q;
	assign done   = done_q;

	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("two result strobes in a row");

	a_running_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(running_q) < 32'(TASK_COUNT))
		else $error("running task outside the table");

	a_no_scan_at_emit: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !(cmd.emit_tick || cmd.emit_rpt) && !done_q)
		else $error("result produced while a scan is in flight");

endmodule

`default_nettype wire
